>>> hw/rtl/shtp_sh2_report_parser_macros.svh
// Assertion macros for the SHTP / SH-2 report parser.
// Expects clk and arst_n in the scope of every use.
`ifndef SHTP_SH2_REPORT_PARSER_MACROS_SVH
`define SHTP_SH2_REPORT_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHTP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/shtp_pkg.sv
// Shared types, codes and the report-ID length table of the SHTP report parser.
// No dependencies; imported by shtp_report_decode, the parser top level and the testbench.
`timescale 1ns / 1ps

package shtp_pkg;

	localparam int STORE_BYTES = 16;
	localparam int IDX_W       = $clog2(STORE_BYTES);

	// Register indexes of the configuration port
	localparam logic CFG_KEEP_LIMIT  = 1'b0;
	localparam logic CFG_DECODE_MASK = 1'b1;

	localparam logic [14:0] KEEP_LIMIT_RST  = 15'd320;
	localparam logic [5:0]  DECODE_MASK_RST = 6'd56;
	localparam logic [15:0] LEN_BUS_FAULT   = 16'hFFFF;
	localparam logic [14:0] HDR_BYTES       = 15'd4;
	localparam logic [7:0]  NUM_CHANNELS    = 8'd6;

	// SH-2 report IDs
	localparam logic [7:0] RID_ACCEL     = 8'h01;
	localparam logic [7:0] RID_GYRO      = 8'h02;
	localparam logic [7:0] RID_MAG       = 8'h03;
	localparam logic [7:0] RID_LIN_ACCEL = 8'h04;
	localparam logic [7:0] RID_ROT_VEC   = 8'h05;
	localparam logic [7:0] RID_GRAVITY   = 8'h06;
	localparam logic [7:0] RID_GYRO_UNC  = 8'h07;
	localparam logic [7:0] RID_GAME_ROT  = 8'h08;
	localparam logic [7:0] RID_MAG_UNC   = 8'h0F;
	localparam logic [7:0] RID_REBASE    = 8'hFA;
	localparam logic [7:0] RID_TIMEBASE  = 8'hFB;

	typedef enum logic [1:0] {
		MODE_HEADER,
		MODE_HEADER_BAD,
		MODE_BODY,
		MODE_IDLE
	} mode_t;

	typedef enum logic [2:0] {
		KIND_HEADER,
		KIND_BADLEN,
		KIND_SHORT,
		KIND_REPORT,
		KIND_UNKNOWN,
		KIND_TRUNC,
		KIND_END
	} kind_t;

	typedef logic [STORE_BYTES-1:0][7:0] rpt_bytes_t;

	// Decoded fields of one complete report
	typedef struct packed {
		logic [7:0]         report_id;
		logic [4:0]         report_length;
		logic [7:0]         sequence_res;
		logic [1:0]         accuracy;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [31:0] time_delta;
	} rpt_fields_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         channel;
		logic [7:0]         sequence_res;
		logic [14:0]        cargo_length;
		logic [7:0]         report_id;
		logic [4:0]         report_length;
		logic [1:0]         accuracy;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [31:0] time_delta;
		logic               packet_end;
	} result_t;

	function automatic logic [4:0] shtp_table_len(input logic [7:0] id);
		logic [4:0] len;
		case (id) inside
			RID_TIMEBASE, RID_REBASE:                                   len = 5'd5;
			RID_ACCEL, RID_GYRO, RID_MAG, RID_LIN_ACCEL, RID_GRAVITY:  len = 5'd10;
			RID_ROT_VEC:                                                len = 5'd14;
			RID_GYRO_UNC, RID_MAG_UNC:                                  len = 5'd16;
			RID_GAME_ROT:                                               len = 5'd12;
			default:                                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

>>> hw/rtl/shtp_rx_if.sv
// Receive channel of the SHTP report parser: one byte plus start flag per request.
// No dependencies.
`timescale 1ns / 1ps

interface shtp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       start_flag;

	modport source(output valid, rx_byte, start_flag, input ready);
	modport sink(input valid, rx_byte, start_flag, output ready);
endinterface

>>> hw/rtl/shtp_res_if.sv
// Result channel of the SHTP report parser: one parse result per request.
// No dependencies.
`timescale 1ns / 1ps

interface shtp_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [7:0]         channel;
	logic [7:0]         sequence_res;
	logic [14:0]        cargo_length;
	logic [7:0]         report_id;
	logic [4:0]         report_length;
	logic [1:0]         accuracy;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic signed [31:0] time_delta;
	logic               packet_end;

	modport source(output valid, kind, channel, sequence_res, cargo_length, report_id,
		report_length, accuracy, axis_x, axis_y, axis_z, time_delta, packet_end,
		input ready);
	modport sink(input valid, kind, channel, sequence_res, cargo_length, report_id,
		report_length, accuracy, axis_x, axis_y, axis_z, time_delta, packet_end,
		output ready);
endinterface

>>> hw/rtl/shtp_report_decode.sv
// Field extraction of one complete SH-2 report from its stored bytes.
// Depends on shtp_pkg.
`timescale 1ns / 1ps

module shtp_report_decode import shtp_pkg::*; (
	input  rpt_bytes_t  bytes,
	output rpt_fields_t fields
);

	logic [7:0] id;

	assign id = bytes[0];

	always_comb begin
		fields               = '0;
		fields.report_id     = id;
		fields.report_length = shtp_table_len(id);
		case (id) inside
			RID_TIMEBASE, RID_REBASE: begin
				fields.time_delta = {bytes[4], bytes[3], bytes[2], bytes[1]};
			end
			RID_ACCEL, RID_GYRO, RID_MAG, RID_LIN_ACCEL, RID_GRAVITY: begin
				fields.sequence_res = bytes[1];
				fields.accuracy     = bytes[2][1:0];
				fields.axis_x       = {bytes[5], bytes[4]};
				fields.axis_y       = {bytes[7], bytes[6]};
				fields.axis_z       = {bytes[9], bytes[8]};
			end
			default: begin
				fields.sequence_res = bytes[1];
			end
		endcase
	end

endmodule

>>> hw/rtl/shtp_sh2_report_parser.sv
// Top level of the SHTP / SH-2 sensor report parser.
// Depends on shtp_pkg, shtp_rx_if, shtp_res_if, shtp_report_decode and the macros header.
//
//   channel | dir | payload                                   | request moves
//   --------+-----+-------------------------------------------+-------------------------
//   rx      | in  | rx_byte, start_flag                       | one received byte
//   res     | out | kind, channel, ... , time_delta, packet_end | zero or one per byte
//   cfg     | in  | cfg_we, cfg_index, cfg_data               | one register write
//
// One byte per cycle while rx is ready: every rx request is parsed in the cycle it is
// accepted and its result, if any, lands in the result register at that same edge.
// rx stays ready while the result register is empty or being drained this cycle, so a
// stall on res holds rx only while a result waits. Reset (arst_n low) puts the parser
// in header phase with the default keep limit and channel mask; no clearing pass.
`timescale 1ns / 1ps
`include "shtp_sh2_report_parser_macros.svh"

module shtp_sh2_report_parser import shtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data,
	shtp_rx_if.sink     rx,
	shtp_res_if.source  res
);

	// Configuration registers
	logic [14:0] keep_limit_q;
	logic [5:0]  decode_mask_q;

	// Parse state
	mode_t            mode_q, mode_n;
	logic [14:0]      pos_q, pos_n;
	logic [7:0]       len_low_q, len_low_n;
	logic [14:0]      len_q, len_n;
	logic [7:0]       chan_q, chan_n;
	logic [7:0]       seq_q, seq_n;
	logic             stop_q, stop_n;
	logic [4:0]       left_q, left_n;
	logic [IDX_W-1:0] idx_q, idx_n;

	// Report byte store, written one byte per accepted body byte of a decoded report
	rpt_bytes_t       store_q;
	rpt_bytes_t       view;
	logic             store_we;
	logic [IDX_W-1:0] store_addr;

	// Result register
	logic    res_valid_q;
	result_t res_q;
	result_t res_n;
	logic    have_n;

	// Shared decode of the current byte
	logic        rx_acc;
	logic [7:0]  b;
	mode_t       mode_e;
	logic [14:0] pos_e;
	logic        in_hdr, in_body, hdr_end;
	logic [15:0] raw_len;
	logic [14:0] eff;
	logic [7:0]  mask_ext;
	logic        chan_ok, dec, start_rpt, cont_rpt, done_rpt;
	logic [4:0]  rl;
	logic        fits, last;
	rpt_fields_t rpt;

	assign rx.ready = !res_valid_q || res.ready;
	assign rx_acc   = rx.valid && rx.ready;
	assign b        = rx.rx_byte;

	// A start flag restarts the header before anything else looks at the byte
	assign mode_e  = rx.start_flag ? MODE_HEADER : mode_q;
	assign pos_e   = rx.start_flag ? '0 : pos_q;
	assign in_hdr  = (mode_e == MODE_HEADER) || (mode_e == MODE_HEADER_BAD);
	assign in_body = (mode_e == MODE_BODY);
	assign hdr_end = in_hdr && (pos_e[1:0] == 2'd3);
	assign raw_len = {b, len_low_q};

	// Decoded span: the smaller of packet length and keep limit
	assign eff      = (len_q < keep_limit_q) ? len_q : keep_limit_q;
	assign mask_ext = {2'b00, decode_mask_q};
	assign chan_ok  = (chan_q < NUM_CHANNELS) && mask_ext[chan_q[2:0]];
	assign dec      = in_body && chan_ok && !stop_q && (pos_e < eff);

	assign rl        = shtp_table_len(b);
	assign fits      = ({1'b0, pos_e} + {11'd0, rl}) <= {1'b0, eff};
	assign start_rpt = dec && (left_q == '0);
	assign cont_rpt  = dec && (left_q != '0);
	assign done_rpt  = cont_rpt && (left_q == 5'd1);
	assign last      = ({1'b0, pos_e} + 16'd1) >= {1'b0, len_q};

	// Store as seen by the decoder: the byte that completes a report is not yet written
	always_comb begin
		view = store_q;
		view[idx_q] = b;
	end

	shtp_report_decode u_decode (
		.bytes  (view),
		.fields (rpt)
	);

	// Next state
	always_comb begin
		mode_n     = mode_e;
		pos_n      = pos_e;
		len_low_n  = len_low_q;
		len_n      = len_q;
		chan_n     = chan_q;
		seq_n      = seq_q;
		stop_n     = stop_q;
		left_n     = left_q;
		idx_n      = idx_q;
		store_we   = 1'b0;
		store_addr = idx_q;
		unique case (mode_e)
			MODE_HEADER, MODE_HEADER_BAD: begin
				case (pos_e[1:0])
					2'd0: begin
						len_low_n = b;
						pos_n     = 15'd1;
					end
					2'd1: begin
						mode_n = (raw_len == LEN_BUS_FAULT) ? MODE_HEADER_BAD : MODE_HEADER;
						len_n  = raw_len[14:0];
						pos_n  = 15'd2;
					end
					2'd2: begin
						chan_n = b;
						pos_n  = 15'd3;
					end
					default: begin
						seq_n = b;
						if (mode_e == MODE_HEADER_BAD || len_q < HDR_BYTES) begin
							mode_n = MODE_IDLE;
						end else begin
							mode_n = (len_q == HDR_BYTES) ? MODE_IDLE : MODE_BODY;
							if (len_q != HDR_BYTES) begin
								stop_n = 1'b0;
								left_n = '0;
								idx_n  = '0;
							end
							pos_n = HDR_BYTES;
						end
					end
				endcase
			end
			MODE_BODY: begin
				if (start_rpt) begin
					if (rl == '0 || !fits) begin
						stop_n = 1'b1;
					end else begin
						store_we   = 1'b1;
						store_addr = '0;
						idx_n      = IDX_W'(1);
						left_n     = rl - 5'd1;
					end
				end else if (cont_rpt) begin
					store_we = 1'b1;
					idx_n    = idx_q + IDX_W'(1);
					left_n   = left_q - 5'd1;
				end
				pos_n = pos_e + 15'd1;
				if (last) begin
					mode_n = MODE_IDLE;
				end
			end
			default: begin
				// Idle: drop bytes until a start flag
			end
		endcase
	end

	// Result of the current byte
	always_comb begin
		res_n              = '0;
		res_n.kind         = KIND_END;
		res_n.channel      = chan_q;
		res_n.cargo_length = len_q;
		have_n             = 1'b0;
		if (hdr_end) begin
			have_n           = 1'b1;
			res_n.packet_end = 1'b1;
			if (mode_e == MODE_HEADER_BAD) begin
				res_n.kind = KIND_BADLEN;
			end else if (len_q < HDR_BYTES) begin
				res_n.kind = KIND_SHORT;
			end else begin
				res_n.kind         = KIND_HEADER;
				res_n.sequence_res = b;
				res_n.packet_end   = (len_q == HDR_BYTES);
			end
		end else if (in_body) begin
			if (start_rpt && rl == '0) begin
				have_n          = 1'b1;
				res_n.kind      = KIND_UNKNOWN;
				res_n.report_id = b;
			end else if (start_rpt && !fits) begin
				have_n              = 1'b1;
				res_n.kind          = KIND_TRUNC;
				res_n.report_id     = b;
				res_n.report_length = rl;
			end else if (done_rpt) begin
				have_n              = 1'b1;
				res_n.kind          = KIND_REPORT;
				res_n.report_id     = rpt.report_id;
				res_n.report_length = rpt.report_length;
				res_n.sequence_res  = rpt.sequence_res;
				res_n.accuracy      = rpt.accuracy;
				res_n.axis_x        = rpt.axis_x;
				res_n.axis_y        = rpt.axis_y;
				res_n.axis_z        = rpt.axis_z;
				res_n.time_delta    = rpt.time_delta;
			end
			// Last byte of the packet always reports; END when nothing else did
			if (last) begin
				have_n           = 1'b1;
				res_n.packet_end = 1'b1;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit_q  <= KEEP_LIMIT_RST;
			decode_mask_q <= DECODE_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEEP_LIMIT:  keep_limit_q  <= cfg_data;
				CFG_DECODE_MASK: decode_mask_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Parse state advances only on an accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_HEADER;
			pos_q     <= '0;
			len_low_q <= '0;
			len_q     <= '0;
			chan_q    <= '0;
			seq_q     <= '0;
			stop_q    <= 1'b0;
			left_q    <= '0;
			idx_q     <= '0;
		end else if (rx_acc) begin
			mode_q    <= mode_n;
			pos_q     <= pos_n;
			len_low_q <= len_low_n;
			len_q     <= len_n;
			chan_q    <= chan_n;
			seq_q     <= seq_n;
			stop_q    <= stop_n;
			left_q    <= left_n;
			idx_q     <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc && store_we) begin
			store_q[store_addr] <= b;
		end
	end

	// Result register: load on a byte with a result, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_acc) begin
			res_valid_q <= have_n;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc && have_n) begin
			res_q <= res_n;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.kind          = res_q.kind;
	assign res.channel       = res_q.channel;
	assign res.sequence_res  = res_q.sequence_res;
	assign res.cargo_length  = res_q.cargo_length;
	assign res.report_id     = res_q.report_id;
	assign res.report_length = res_q.report_length;
	assign res.accuracy      = res_q.accuracy;
	assign res.axis_x        = res_q.axis_x;
	assign res.axis_y        = res_q.axis_y;
	assign res.axis_z        = res_q.axis_z;
	assign res.time_delta    = res_q.time_delta;
	assign res.packet_end    = res_q.packet_end;

	// A result that ends the packet leaves the parser idle
	`SHTP_ASSERT_NEXT(a_end_goes_idle, rx_acc && have_n && res_n.packet_end, mode_q == MODE_IDLE, "packet end did not idle the parser")
	// A byte without a result leaves the result register empty
	`SHTP_ASSERT_NEXT(a_no_phantom, rx_acc && !have_n, !res_valid_q, "result register holds a result for a silent byte")
	// A completed report leaves no bytes pending and decoding still enabled
	`SHTP_ASSERT_NEXT(a_report_done, rx_acc && done_rpt, left_q == '0 && !stop_q, "report counter not drained after a complete report")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the SHTP / SH-2 report parser: byte stream in, parse results out.
// Depends on shtp_pkg, shtp_rx_if, shtp_res_if and the parser top level; builds its own
// expected results from a byte-level parser model kept in this file.
`timescale 1ns / 1ps

module tb_top;
	import shtp_pkg::*;

	// Stimulus rows of the directed part; "typed" rows carry a hand-written result
	typedef struct {
		logic [7:0] data;
		bit         sof;
		bit         typed;
		result_t    want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [14:0] cfg_data;

	shtp_rx_if  rx_ch();
	shtp_res_if res_ch();

	shtp_sh2_report_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	// Parser model state, mirrors what the block keeps per packet
	mode_t       pmode;
	logic [14:0] bpos;
	logic [7:0]  len_lo;
	logic [14:0] plen;
	logic [7:0]  pchan;
	logic [7:0]  pseq;
	bit          stopped;
	logic [4:0]  left;
	logic [3:0]  ridx;
	logic [7:0]  rstore [STORE_BYTES];
	logic [14:0] keep_lim;
	logic [5:0]  chan_mask;

	result_t     pending_results[$];
	stim_row_t   directed_rows[$];
	logic [7:0]  pkt[$];

	int err_count;
	int reported;
	int counted;
	int rx_gap_pct;
	int res_stall_pct;
	int holds_asked;
	int holds_done;
	int hold_left;

	// Table length of an SH-2 report, 0 for an ID the parser does not know
	function automatic int report_size(input logic [7:0] id);
		case (id)
			RID_TIMEBASE, RID_REBASE:                                  return 5;
			RID_ACCEL, RID_GYRO, RID_MAG, RID_LIN_ACCEL, RID_GRAVITY: return 10;
			RID_ROT_VEC:                                               return 14;
			RID_GYRO_UNC, RID_MAG_UNC:                                 return 16;
			RID_GAME_ROT:                                              return 12;
			default:                                                   return 0;
		endcase
	endfunction

	function automatic logic [7:0] known_id(input int sel);
		case (sel)
			0:       return RID_ACCEL;
			1:       return RID_GYRO;
			2:       return RID_MAG;
			3:       return RID_LIN_ACCEL;
			4:       return RID_ROT_VEC;
			5:       return RID_GRAVITY;
			6:       return RID_GYRO_UNC;
			7:       return RID_GAME_ROT;
			8:       return RID_MAG_UNC;
			9:       return RID_REBASE;
			default: return RID_TIMEBASE;
		endcase
	endfunction

	function automatic bit is_vector(input logic [7:0] id);
		return id == RID_ACCEL || id == RID_GYRO || id == RID_MAG ||
			id == RID_LIN_ACCEL || id == RID_GRAVITY;
	endfunction

	// Short form for the hand-written rows: header-level results only
	function automatic result_t brief(input kind_t k, input logic [7:0] ch,
			input logic [7:0] sq, input logic [14:0] ln, input bit fin);
		result_t r;
		r = '0;
		r.kind = k;
		r.channel = ch;
		r.sequence_res = sq;
		r.cargo_length = ln;
		r.packet_end = fin;
		return r;
	endfunction

	// Advance the parser model by one accepted byte; return 1 when it yields a result
	function automatic bit parse_byte(input logic [7:0] b, input bit sof, output result_t r);
		logic [15:0] raw;
		int pos;
		int eff;
		int rl;
		bit have;
		r = '0;
		have = 1'b0;
		if (sof) begin
			pmode = MODE_HEADER;
			bpos = '0;
		end
		if (pmode == MODE_IDLE)
			return 1'b0;

		if (pmode != MODE_BODY) begin
			case (bpos[1:0])
				2'd0: len_lo = b;
				2'd1: begin
					raw = {b, len_lo};
					pmode = (raw == LEN_BUS_FAULT) ? MODE_HEADER_BAD : MODE_HEADER;
					plen = raw[14:0];
				end
				2'd2: pchan = b;
				default: begin
					pseq = b;
					r.channel = pchan;
					r.cargo_length = plen;
					r.packet_end = 1'b1;
					if (pmode == MODE_HEADER_BAD) begin
						r.kind = KIND_BADLEN;
						pmode = MODE_IDLE;
						return 1'b1;
					end
					if (plen < HDR_BYTES) begin
						r.kind = KIND_SHORT;
						pmode = MODE_IDLE;
						return 1'b1;
					end
					r.kind = KIND_HEADER;
					r.sequence_res = pseq;
					if (plen == HDR_BYTES) begin
						pmode = MODE_IDLE;
					end else begin
						r.packet_end = 1'b0;
						pmode = MODE_BODY;
						stopped = 1'b0;
						left = '0;
						ridx = '0;
					end
					bpos = HDR_BYTES;
					return 1'b1;
				end
			endcase
			bpos = {13'd0, bpos[1:0]} + 15'd1;
			return 1'b0;
		end

		// Cargo byte: split into reports on decoded channels, within the kept span
		pos = int'(bpos);
		eff = (plen < keep_lim) ? int'(plen) : int'(keep_lim);
		r.channel = pchan;
		r.cargo_length = plen;
		if (pchan < NUM_CHANNELS && chan_mask[pchan[2:0]] && !stopped && pos < eff) begin
			if (left == 0) begin
				rl = report_size(b);
				if (rl == 0) begin
					r.kind = KIND_UNKNOWN;
					r.report_id = b;
					stopped = 1'b1;
					have = 1'b1;
				end else if (pos + rl > eff) begin
					r.kind = KIND_TRUNC;
					r.report_id = b;
					r.report_length = 5'(rl);
					stopped = 1'b1;
					have = 1'b1;
				end else begin
					rstore[0] = b;
					ridx = 4'd1;
					left = 5'(rl - 1);
				end
			end else begin
				rstore[ridx] = b;
				ridx = ridx + 4'd1;
				left = left - 5'd1;
				if (left == 0) begin
					r.kind = KIND_REPORT;
					r.report_id = rstore[0];
					r.report_length = 5'(report_size(rstore[0]));
					if (rstore[0] == RID_TIMEBASE || rstore[0] == RID_REBASE) begin
						r.time_delta = {rstore[4], rstore[3], rstore[2], rstore[1]};
					end else begin
						r.sequence_res = rstore[1];
						if (is_vector(rstore[0])) begin
							r.accuracy = rstore[2][1:0];
							r.axis_x = {rstore[5], rstore[4]};
							r.axis_y = {rstore[7], rstore[6]};
							r.axis_z = {rstore[9], rstore[8]};
						end
					end
					have = 1'b1;
				end
			end
		end
		bpos = 15'(pos + 1);
		if (pos + 1 >= int'(plen)) begin
			pmode = MODE_IDLE;
			if (!have)
				r.kind = KIND_END;
			r.packet_end = 1'b1;
			return 1'b1;
		end
		return have;
	endfunction

	function automatic string fmt_result(input result_t r);
		return $sformatf({"kind=%0d ch=%02h seq=%02h len=%04h id=%02h rlen=%0d acc=%0d ",
			"x=%0d y=%0d z=%0d dt=%0d end=%0b"}, r.kind, r.channel, r.sequence_res,
			r.cargo_length, r.report_id, r.report_length, r.accuracy, r.axis_x, r.axis_y,
			r.axis_z, r.time_delta, r.packet_end);
	endfunction

	function automatic string diff_fields(input result_t e, input result_t a);
		string s;
		s = "";
		if (e.kind !== a.kind)                   s = {s, " kind"};
		if (e.channel !== a.channel)             s = {s, " channel"};
		if (e.sequence_res !== a.sequence_res)   s = {s, " sequence_res"};
		if (e.cargo_length !== a.cargo_length)   s = {s, " cargo_length"};
		if (e.report_id !== a.report_id)         s = {s, " report_id"};
		if (e.report_length !== a.report_length) s = {s, " report_length"};
		if (e.accuracy !== a.accuracy)           s = {s, " accuracy"};
		if (e.axis_x !== a.axis_x)               s = {s, " axis_x"};
		if (e.axis_y !== a.axis_y)               s = {s, " axis_y"};
		if (e.axis_z !== a.axis_z)               s = {s, " axis_z"};
		if (e.time_delta !== a.time_delta)       s = {s, " time_delta"};
		if (e.packet_end !== a.packet_end)       s = {s, " packet_end"};
		return s;
	endfunction

	// Offer one byte request, gapping at random first; run the model once it is taken.
	// A typed row replaces the model's result with the hand-written one.
	task automatic push_byte(input logic [7:0] b, input bit sof,
			input bit typed = 1'b0, input result_t want = '0);
		result_t r;
		bit got;
		bit ignored;
		while ($urandom_range(0, 99) < rx_gap_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		rx_ch.start_flag <= sof;
		do @(posedge clk); while (!rx_ch.ready);
		ignored = (pmode == MODE_IDLE) && !sof;
		got = parse_byte(b, sof, r);
		if (typed)
			pending_results.push_back(want);
		else if (got)
			pending_results.push_back(r);
		if (!ignored)
			counted++;
	endtask

	// Drop valid and wait until every expected result has come back, with a cap
	task automatic drain_results();
		int n;
		n = 0;
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
	endtask

	// Write both registers on consecutive edges; the block must be idle
	task automatic set_config(input logic [14:0] kl, input logic [5:0] mask);
		drain_results();
		// a byte with no result may still be in flight: let it settle
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_KEEP_LIMIT;
		cfg_data <= kl;
		@(posedge clk);
		keep_lim = kl;
		cfg_index <= CFG_DECODE_MASK;
		cfg_data <= {9'd0, mask};
		@(posedge clk);
		chan_mask = mask;
		cfg_we <= 1'b0;
	endtask

	// Append one report with random content to the packet under construction
	task automatic add_report(input logic [7:0] id, input int size);
		pkt.push_back(id);
		repeat (size - 1) pkt.push_back(8'($urandom));
	endtask

	// One random packet: mostly well-formed report packets, plus aborted packets,
	// header errors, header-only packets and plain noise
	task automatic send_packet();
		int shape;
		int n;
		int len;
		logic [7:0] id;
		logic [7:0] ch;
		logic [15:0] raw;
		logic cont;
		shape = $urandom_range(0, 99);
		pkt.delete();
		if (shape >= 95) begin
			repeat ($urandom_range(1, 8))
				push_byte(8'($urandom), $urandom_range(0, 4) == 0);
			return;
		end
		ch = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
		cont = 1'($urandom);
		if (shape < 75) begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 9) == 0) begin
					// unknown ID: stops decoding, whatever follows is filler
					do id = 8'($urandom); while (report_size(id) != 0);
					add_report(id, $urandom_range(1, 3));
				end else begin
					id = known_id($urandom_range(0, 10));
					add_report(id, report_size(id));
				end
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
		end
		len = 4 + pkt.size();
		// cut the length short now and then so that a report runs past the packet end
		if (shape < 75 && $urandom_range(0, 6) == 0)
			len -= $urandom_range(1, 4);

		if (shape >= 75 && shape < 80)
			raw = LEN_BUS_FAULT;
		else if (shape >= 80 && shape < 85)
			raw = {cont, 15'($urandom_range(0, 3))};
		else if (shape >= 85)
			raw = {cont, HDR_BYTES};
		else
			raw = {cont, 15'(len)};

		push_byte(raw[7:0], 1'b1);
		push_byte(raw[15:8], 1'b0);
		push_byte(ch, 1'b0);
		push_byte(8'($urandom), 1'b0);

		if (shape < 65)
			n = len - 4;
		else if (shape < 75)
			n = (len > 5) ? int'($urandom_range(0, len - 5)) : 0;  // aborted by the next start flag
		else
			n = $urandom_range(0, 3);        // trailing bytes the parser ignores
		for (int i = 0; i < n; i++)
			push_byte((i < pkt.size()) ? pkt[i] : 8'($urandom), 1'b0);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit, far above the slowest correct run
	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Result sink: random stalls, plus a long hold-off whenever the stimulus asks for one
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else if (holds_done < holds_asked) begin
			res_ch.ready <= 1'b0;
			hold_left = 80;
			holds_done++;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= res_stall_pct);
		end
	end

	// Check every result request against the oldest expectation
	always @(posedge clk) begin
		result_t act;
		result_t exp_r;
		string bad;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			act.kind = kind_t'(res_ch.kind);
			act.channel = res_ch.channel;
			act.sequence_res = res_ch.sequence_res;
			act.cargo_length = res_ch.cargo_length;
			act.report_id = res_ch.report_id;
			act.report_length = res_ch.report_length;
			act.accuracy = res_ch.accuracy;
			act.axis_x = res_ch.axis_x;
			act.axis_y = res_ch.axis_y;
			act.axis_z = res_ch.axis_z;
			act.time_delta = res_ch.time_delta;
			act.packet_end = res_ch.packet_end;
			if (pending_results.size() == 0) begin
				err_count++;
				if (reported < 10) begin
					$display("unexpected result: %s", fmt_result(act));
					reported++;
				end
			end else begin
				exp_r = pending_results.pop_front();
				bad = diff_fields(exp_r, act);
				if (bad != "") begin
					err_count++;
					if (reported < 10) begin
						$display("mismatch in%s", bad);
						$display("  expected %s", fmt_result(exp_r));
						$display("  actual   %s", fmt_result(act));
						reported++;
					end
				end
			end
		end
	end

	// Stimulus
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_KEEP_LIMIT;
		cfg_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		rx_ch.start_flag = 1'b0;
		res_ch.ready = 1'b0;
		err_count = 0;
		reported = 0;
		counted = 0;
		holds_asked = 0;
		holds_done = 0;
		hold_left = 0;
		rx_gap_pct = 12;
		res_stall_pct = 46;

		// model reset state
		pmode = MODE_HEADER;
		bpos = '0;
		len_lo = '0;
		plen = '0;
		pchan = '0;
		pseq = '0;
		stopped = 1'b0;
		left = '0;
		ridx = '0;
		keep_lim = KEEP_LIMIT_RST;
		chan_mask = DECODE_MASK_RST;
		foreach (rstore[i]) rstore[i] = '0;

		// Directed rows. Right after reset the parser is in header phase, so the
		// bus-fault header goes in without a start flag; the byte after it is ignored.
		directed_rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h05, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h09, 1'b0, 1'b1,
			brief(KIND_BADLEN, 8'h05, 8'h00, 15'h7FFF, 1'b1)});
		directed_rows.push_back('{8'h33, 1'b0, 1'b0, '0});
		// short packet, length 2
		directed_rows.push_back('{8'h02, 1'b1, 1'b0, '0});
		directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h03, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h07, 1'b0, 1'b1,
			brief(KIND_SHORT, 8'h03, 8'h00, 15'd2, 1'b1)});
		// header-only packet, continuation bit set: header result ends the packet
		directed_rows.push_back('{8'h04, 1'b1, 1'b0, '0});
		directed_rows.push_back('{8'h80, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h02, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h11, 1'b0, 1'b1,
			brief(KIND_HEADER, 8'h02, 8'h11, 15'd4, 1'b1)});
		// timebase report on decoded channel 3, most negative delta, last byte of packet
		directed_rows.push_back('{8'h09, 1'b1, 1'b0, '0});
		directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h03, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h01, 1'b0, 1'b1,
			brief(KIND_HEADER, 8'h03, 8'h01, 15'd9, 1'b0)});
		directed_rows.push_back('{RID_TIMEBASE, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		directed_rows.push_back('{8'h80, 1'b0, 1'b0, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_byte(directed_rows[i].data, directed_rows[i].sof,
				directed_rows[i].typed, directed_rows[i].want);

		// Random phases, each with its own register setting; each pair of phases shares an idle profile
		for (int ph = 0; ph < 6; ph++) begin
			bit paused;
			int target;
			paused = 1'b0;
			case (ph)
				0: set_config(15'd4, 6'd63);       // keep limit too small for any report
				1: set_config(15'h7FFF, 6'd63);
				2: set_config(15'd5, 6'd56);
				3: set_config(15'($urandom_range(6, 60)), 6'd0);
				4: set_config(15'd20, 6'($urandom));
				default: set_config(15'($urandom_range(4, 32767)), 6'($urandom));
			endcase
			case (ph / 2)
				0: begin
					rx_gap_pct = 12;
					res_stall_pct = 46;
				end
				1: begin
					rx_gap_pct = 46;
					res_stall_pct = 12;
				end
				default: begin
					rx_gap_pct = 0;
					res_stall_pct = 0;
				end
			endcase
			// hold the sink off for a long stretch while bytes keep coming
			if (ph == 1)
				holds_asked++;
			target = counted + 100;
			while (counted < target) begin
				// halt the sender once until every expected result is back
				if (ph == 3 && !paused && counted + 50 >= target) begin
					drain_results();
					paused = 1'b1;
				end
				send_packet();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		err_count += pending_results.size();
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/shtp_pkg.sv
hw/rtl/shtp_rx_if.sv
hw/rtl/shtp_res_if.sv
hw/rtl/shtp_report_decode.sv
hw/rtl/shtp_sh2_report_parser.sv
sim/tb_top.sv
